/* rtl/core/steepest_descent_particle_step_unit_defines.svh */
// Assertion macros for the steepest-descent particle step unit.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef STEEPEST_DESCENT_PARTICLE_STEP_UNIT_DEFINES_SVH
`define STEEPEST_DESCENT_PARTICLE_STEP_UNIT_DEFINES_SVH

// Same-cycle implication, quiet during reset.
`define SDPS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet during reset.
`define SDPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/sdps_pkg.sv */
// Shared widths, register codes and beat types of the particle step unit.
// No dependencies.
package sdps_pkg;

  localparam int NumAxes  = 3;
  localparam int ForceW   = 24;
  localparam int PosW     = 32;
  localparam int GainW    = 24;
  localparam int LimW     = 23;
  localparam int ProdW    = 48;
  localparam int SqW      = 47;
  localparam int FsqW     = 48;
  localparam int LimSqW   = 2 * LimW;
  localparam int DpW      = LimW + 1;
  localparam int FracBits = 16;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 24;

  typedef enum logic [CfgIdxW-1:0] {
    RegDamping    = 2'd0,
    RegStepLimit  = 2'd1,
    RegForceLimit = 2'd2
  } sdps_reg_e;

  // One particle as it enters the lanes.
  typedef struct packed {
    logic [NumAxes-1:0][ForceW-1:0] frc;
    logic [NumAxes-1:0][PosW-1:0]   pos;
    logic [NumAxes-1:0]             fixed;
    logic                           last;
  } sdps_beat_t;

  // Pipeline control handed to the merge stage.
  typedef struct packed {
    logic adv;    // whole pipe moves this cycle
    logic move2;  // a valid particle leaves stage 2
  } sdps_ctl_t;

endpackage

/* rtl/core/steepest_descent_particle_step_unit.sv */
// Steepest-descent particle step unit. One particle per cycle, unless out_stall_i holds
// the pipe, through three axis lanes and a merge stage with the sweep maximum. Depends
// on sdps_pkg, sdps_lane, sdps_merge and the assertion macro header.
//
// Takes one particle per beat and returns one updated particle per beat, in order.
// Throughput is one particle per clock unless out_stall_i holds the pipe; there are
// three register stages, and a result passes through them into the output register;
// out_stall_i holds the whole pipe. The lanes hold one 25x24 multiplier and one
// 24x24 squarer each in the first stage; the sweep maximum is a compare-and-update
// register, which is what lets consecutive particles follow with no gap. in_stall_o
// comes from a one-beat skid register, so it does not depend combinationally on
// out_stall_i. A beat whose sweep_end is set compares the sweep maximum (including
// itself) against force_limit squared, reports converged when it is below, and clears
// the maximum. force_limit squared is registered from the stored force_limit after a
// write. Write configuration only while idle.
`include "steepest_descent_particle_step_unit_defines.svh"

module steepest_descent_particle_step_unit
  import sdps_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration write port
  input  logic                     cfg_we_i,
  input  logic [CfgIdxW-1:0]       cfg_idx_i,
  input  logic [CfgDataW-1:0]      cfg_wdata_i,
  // particle in
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [ForceW-1:0] force_x_i,
  input  logic signed [ForceW-1:0] force_y_i,
  input  logic signed [ForceW-1:0] force_z_i,
  input  logic signed [PosW-1:0]   pos_x_i,
  input  logic signed [PosW-1:0]   pos_y_i,
  input  logic signed [PosW-1:0]   pos_z_i,
  input  logic [NumAxes-1:0]       fixed_axes_i,
  input  logic                     sweep_end_i,
  // particle out
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [PosW-1:0]   new_x_o,
  output logic signed [PosW-1:0]   new_y_o,
  output logic signed [PosW-1:0]   new_z_o,
  output logic                     end_of_sweep_o,
  output logic                     converged_o
);

  // config registers
  logic [GainW-1:0]  gain_q;
  logic [LimW-1:0]   step_lim_q;
  logic [LimW-1:0]   force_lim_q;
  logic [LimSqW-1:0] limit_sq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q      <= '0;
      step_lim_q  <= '0;
      force_lim_q <= '0;
      limit_sq_q  <= '0;
    end else begin
      limit_sq_q <= force_lim_q * force_lim_q;
      if (cfg_we_i) begin
        case (sdps_reg_e'(cfg_idx_i))
          RegDamping:    gain_q      <= cfg_wdata_i[GainW-1:0];
          RegStepLimit:  step_lim_q  <= cfg_wdata_i[LimW-1:0];
          RegForceLimit: force_lim_q <= cfg_wdata_i[LimW-1:0];
          default:       ;
        endcase
      end
    end
  end

  // input beat and skid register
  sdps_beat_t in_beat;
  sdps_beat_t skid_q;
  sdps_beat_t head;
  logic       skid_v_q;
  logic       skid_v_d;
  logic       in_acc;
  logic       head_v;
  logic       adv;
  logic       s1_v_q;
  logic       s2_v_q;
  logic       out_v_q;
  sdps_ctl_t  ctl;

  always_comb begin
    in_beat.frc[0] = force_x_i;
    in_beat.frc[1] = force_y_i;
    in_beat.frc[2] = force_z_i;
    in_beat.pos[0] = pos_x_i;
    in_beat.pos[1] = pos_y_i;
    in_beat.pos[2] = pos_z_i;
    in_beat.fixed  = fixed_axes_i;
    in_beat.last   = sweep_end_i;
  end

  // whole pipe moves unless a finished particle is held at the output
  assign adv        = !(out_v_q && out_stall_i);
  assign in_stall_o = skid_v_q;
  assign in_acc     = in_valid_i && !skid_v_q;
  assign head_v     = skid_v_q || in_valid_i;
  assign head       = skid_v_q ? skid_q : in_beat;

  always_comb begin
    skid_v_d = skid_v_q;
    if (adv) begin
      skid_v_d = 1'b0;
    end else if (in_acc) begin
      skid_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!adv && in_acc) begin
      skid_q <= in_beat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_v_q <= 1'b0;
      s1_v_q   <= 1'b0;
      s2_v_q   <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      skid_v_q <= skid_v_d;
      if (adv) begin
        s1_v_q  <= head_v;
        s2_v_q  <= s1_v_q;
        out_v_q <= s2_v_q;
      end
    end
  end

  assign ctl.adv   = adv;
  assign ctl.move2 = adv && s2_v_q;

  // axis lanes
  logic [NumAxes-1:0][SqW-1:0]  sq;
  logic [NumAxes-1:0][PosW-1:0] new_pos;

  for (genvar g = 0; g < NumAxes; g++) begin : g_lane
    sdps_lane u_lane (
      .clk_i     (clk_i),
      .en_i      (adv),
      .gain_i    (gain_q),
      .lim_i     (step_lim_q),
      .force_i   (head.frc[g]),
      .pos_i     (head.pos[g]),
      .fixed_i   (head.fixed[g]),
      .sq_o      (sq[g]),
      .new_pos_o (new_pos[g])
    );
  end

  // merge: force-square sum, sweep maximum, convergence
  sdps_merge u_merge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .last_i         (head.last),
    .sq_i           (sq),
    .limit_sq_i     (limit_sq_q),
    .end_of_sweep_o (end_of_sweep_o),
    .converged_o    (converged_o)
  );

  assign out_valid_o = out_v_q;
  assign new_x_o     = new_pos[0];
  assign new_y_o     = new_pos[1];
  assign new_z_o     = new_pos[2];

  `SDPS_ASSERT_IMPL(a_skid_fill, $rose(skid_v_q), $past(out_v_q && out_stall_i), "skid filled without stall")
  `SDPS_ASSERT_IMPL(a_skid_out, skid_v_q, out_v_q, "skid holds a beat with empty output")
  `SDPS_ASSERT_IMPL(a_conv_end, out_v_q && converged_o, end_of_sweep_o, "converged off sweep end")

endmodule

/* rtl/core/sdps_lane.sv */
// One axis lane: damped step, clamp, saturating position update, force square.
// Depends on sdps_pkg.
module sdps_lane
  import sdps_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [GainW-1:0]         gain_i,
  input  logic [LimW-1:0]          lim_i,
  input  logic signed [ForceW-1:0] force_i,
  input  logic signed [PosW-1:0]   pos_i,
  input  logic                     fixed_i,
  output logic [SqW-1:0]           sq_o,
  output logic signed [PosW-1:0]   new_pos_o
);

  logic signed [ProdW:0]     prod_full;
  logic signed [ProdW-1:0]   sq_full;
  logic signed [ProdW-1:0]   prod_q;
  logic [SqW-1:0]            sq_q;
  logic signed [PosW-1:0]    pos1_q;
  logic                      fixed1_q;
  logic signed [ProdW-1:0]   shr;
  logic signed [PosW-1:0]    dp;
  logic signed [PosW-1:0]    lim_ext;
  logic signed [PosW-1:0]    dp_clamp;
  logic signed [DpW-1:0]     dp_d;
  logic signed [DpW-1:0]     dp_q;
  logic signed [PosW-1:0]    pos2_q;
  logic signed [PosW:0]      sum;
  logic signed [PosW-1:0]    new_pos_d;
  logic signed [PosW-1:0]    new_pos_q;

  // stage 1: products
  assign prod_full = $signed({1'b0, gain_i}) * force_i;
  assign sq_full   = force_i * force_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q   <= prod_full[ProdW-1:0];
      sq_q     <= fixed_i ? '0 : sq_full[SqW-1:0];
      pos1_q   <= pos_i;
      fixed1_q <= fixed_i;
    end
  end

  // stage 2: floor to Q16.16, clamp to +/- limit, zero if fixed
  assign shr     = prod_q >>> FracBits;
  assign dp      = shr[PosW-1:0];
  assign lim_ext = $signed({{(PosW-LimW){1'b0}}, lim_i});

  always_comb begin
    if (dp > lim_ext) begin
      dp_clamp = lim_ext;
    end else if (dp < -lim_ext) begin
      dp_clamp = -lim_ext;
    end else begin
      dp_clamp = dp;
    end
    dp_d = fixed1_q ? '0 : dp_clamp[DpW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dp_q   <= dp_d;
      pos2_q <= pos1_q;
    end
  end

  // stage 3: add and saturate
  assign sum = {pos2_q[PosW-1], pos2_q} + {{(PosW+1-DpW){dp_q[DpW-1]}}, dp_q};

  always_comb begin
    if (sum[PosW] != sum[PosW-1]) begin
      new_pos_d = sum[PosW] ? {1'b1, {(PosW-1){1'b0}}} : {1'b0, {(PosW-1){1'b1}}};
    end else begin
      new_pos_d = sum[PosW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      new_pos_q <= new_pos_d;
    end
  end

  assign sq_o      = sq_q;
  assign new_pos_o = new_pos_q;

endmodule

/* rtl/core/sdps_merge.sv */
// Merge stage: sums the lane force squares, tracks the sweep maximum, flags convergence.
// Depends on sdps_pkg and the assertion macro header.
`include "steepest_descent_particle_step_unit_defines.svh"

module sdps_merge
  import sdps_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sdps_ctl_t                     ctl_i,
  input  logic                          last_i,
  input  logic [NumAxes-1:0][SqW-1:0]   sq_i,
  input  logic [LimSqW-1:0]             limit_sq_i,
  output logic                          end_of_sweep_o,
  output logic                          converged_o
);

  logic              last1_q;
  logic              last2_q;
  logic [FsqW-1:0]   fsq_d;
  logic [FsqW-1:0]   fsq_q;
  logic [FsqW-1:0]   cand;
  logic [FsqW-1:0]   max_q;
  logic [FsqW-1:0]   max_d;
  logic              conv_d;
  logic              conv_q;
  logic              end_q;

  always_comb begin
    fsq_d = '0;
    for (int i = 0; i < NumAxes; i++) begin
      fsq_d = fsq_d + FsqW'(sq_i[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv) begin
      last1_q <= last_i;
      last2_q <= last1_q;
      fsq_q   <= fsq_d;
    end
  end

  // running maximum; a sweep end compares and clears it
  assign cand   = (fsq_q > max_q) ? fsq_q : max_q;
  assign conv_d = last2_q && (cand < FsqW'(limit_sq_i));

  always_comb begin
    max_d = max_q;
    if (ctl_i.move2) begin
      max_d = last2_q ? '0 : cand;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= '0;
    end else begin
      max_q <= max_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv) begin
      conv_q <= conv_d;
      end_q  <= last2_q;
    end
  end

  assign end_of_sweep_o = end_q;
  assign converged_o    = conv_q;

  `SDPS_ASSERT_NEXT(a_max_cleared, ctl_i.move2 && last2_q, max_q == '0, "max not cleared at sweep end")
  `SDPS_ASSERT_NEXT(a_max_held, !ctl_i.move2, $stable(max_q), "max changed without a particle")
  `SDPS_ASSERT_NEXT(a_max_grows, ctl_i.move2 && !last2_q, max_q >= $past(max_q), "max fell inside a sweep")

endmodule
